FILE: rtl/core/sds_pkg.sv
// sds_pkg: shared constants for the divisor-sum core
// result field widths, saturation limit and beat layout
// no dependencies
`timescale 1ns / 1ps

package sds_pkg;

  // default width of the number field
  localparam int NUM_WIDTH_DEF = 16;

  // result field width and its saturation limit
  localparam int OUT_W = 18;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // result beat: two fields packed, padded to whole bytes
  localparam int OUT_TW = ((2 * OUT_W + 7) / 8) * 8;

endpackage

FILE: rtl/core/sds_rem_unit.sv
// sds_rem_unit: bit-serial restoring remainder unit
// one shift, compare and subtract step per cycle; no package needed
// used by divisor_sum_core
`timescale 1ns / 1ps

module sds_rem_unit #(
  parameter int NUM_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [NUM_WIDTH-1:0] divisor,
  output logic                 done,
  output logic                 rem_zero
);

  localparam int CNT_W = $clog2(NUM_WIDTH + 1);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [NUM_WIDTH-1:0] shreg;
  logic [NUM_WIDTH-1:0] dsr;
  logic [NUM_WIDTH-1:0] rem;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   diff;
  logic [NUM_WIDTH-1:0] rem_next;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, shreg[NUM_WIDTH-1]};
    diff  = trial - {1'b0, dsr};
    if (trial >= {1'b0, dsr}) begin
      rem_next = diff[NUM_WIDTH-1:0];
    end else begin
      rem_next = trial[NUM_WIDTH-1:0];
    end
  end

  assign rem_zero = (rem == '0);

  // control: load on start, step until the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dsr   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[NUM_WIDTH-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

endmodule

FILE: rtl/core/divisor_sum_core.sv
// Divisor-sum core: for each input beat carrying n it returns sigma(n), the sum of all
// divisors of n, and the proper-divisor sum sigma(n) - n, each saturated at 2^18 - 1
// (0 and 0 for n = 0). Every candidate from 1 to n - 1 goes through one shared
// bit-serial remainder unit, one candidate after the other, each sent through the
// S_START and S_WAIT states. One item is worked at a time; s_tready is high only
// while the core is idle. A finished result waits in the output register until taken.
// depends on sds_pkg and sds_rem_unit
`timescale 1ns / 1ps

module divisor_sum_core
  import sds_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((NUM_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // number
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [OUT_TW-1:0]                    m_tdata   // divisor_total, proper_total
);

  // accumulator wide enough for any divisor sum at this number width
  localparam int SUM_W = NUM_WIDTH + 3;
  localparam int SAT_W = (SUM_W > OUT_W + 1) ? SUM_W : OUT_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  state_t               state;
  logic [NUM_WIDTH-1:0] held_number;
  logic [NUM_WIDTH-1:0] candidate;
  logic [SUM_W-1:0]     proper_sum;
  logic                 rem_start;
  logic                 rem_done;
  logic                 rem_zero;
  logic [NUM_WIDTH-1:0] in_number;
  logic [SAT_W-1:0]     total_full;
  logic [SAT_W-1:0]     proper_full;
  logic [OUT_W-1:0]     total_sat;
  logic [OUT_W-1:0]     proper_sat;

  assign in_number = s_tdata[NUM_WIDTH-1:0];
  assign s_tready  = (state == S_IDLE);
  assign rem_start = (state == S_START);

  // shared remainder unit: held_number mod candidate
  sds_rem_unit #(
    .NUM_WIDTH(NUM_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (held_number),
    .divisor  (candidate),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  // final sums and per-field saturation
  always_comb begin
    proper_full = SAT_W'(proper_sum);
    total_full  = SAT_W'(proper_sum) + SAT_W'(held_number);
    total_sat   = (total_full > SAT_W'(OUT_MAX)) ? OUT_MAX : total_full[OUT_W-1:0];
    proper_sat  = (proper_full > SAT_W'(OUT_MAX)) ? OUT_MAX : proper_full[OUT_W-1:0];
  end

  // sequencer, running sum and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      held_number <= '0;
      candidate   <= '0;
      proper_sum  <= '0;
    end else begin
      // a taken beat frees the output register; S_OUT reloads it on its own
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            held_number <= in_number;
            candidate   <= NUM_WIDTH'(1);
            proper_sum  <= '0;
            if (in_number <= NUM_WIDTH'(1)) begin
              state <= S_OUT;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (rem_done) begin
            if (rem_zero) begin
              proper_sum <= proper_sum + SUM_W'(candidate);
            end
            if (candidate == held_number - 1'b1) begin
              state <= S_OUT;
            end else begin
              candidate <= candidate + 1'b1;
              state     <= S_START;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_TW - 2 * OUT_W){1'b0}}, proper_sat, total_sat};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
